// ===== rtl/gif_frame_delay_fixer_top_macros.svh =====
// ----------------------------------------------------------------------------
// gif_frame_delay_fixer_top_macros.svh
// Assertion macros shared by the frame delay fixer RTL.
// ----------------------------------------------------------------------------
`ifndef GIF_FRAME_DELAY_FIXER_TOP_MACROS_SVH
`define GIF_FRAME_DELAY_FIXER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GFDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define GFDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gfdf_pkg.sv =====
// ----------------------------------------------------------------------------
// gfdf_pkg
// Shared types, constants and signature lookup for the frame delay fixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gfdf_pkg;

  // Window and header geometry
  localparam int WIN_LEN = 9;
  localparam int CNT_W   = 4;
  localparam int HDR_LEN = 6;
  localparam int HPOS_W  = 3;

  // Configuration port
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_DELAY = 8'd1;

  localparam logic [15:0] MIN_DELAY_RST  = 16'd2;
  localparam logic [15:0] REPL_DELAY_RST = 16'd10;

  // Graphic control extension marker bytes
  localparam logic [7:0] GCE_B0 = 8'h00;
  localparam logic [7:0] GCE_B1 = 8'h21;
  localparam logic [7:0] GCE_B2 = 8'hF9;
  localparam logic [7:0] GCE_B3 = 8'h04;

  typedef enum logic {
    ST_STREAM,
    ST_FLUSH
  } win_state_t;

  typedef struct packed {
    logic [15:0] min_delay;
    logic [15:0] repl_delay;
  } cfg_t;

  typedef struct packed {
    logic ok;   // header complete and one signature still matching
  } hdr_t;

  // Expected header byte at a given position (GIF87a / GIF89a)
  function automatic logic [7:0] sig_byte(input logic [HPOS_W-1:0] pos, input logic is89);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h47;
      3'd1:    b = 8'h49;
      3'd2:    b = 8'h46;
      3'd3:    b = 8'h38;
      3'd4:    b = is89 ? 8'h39 : 8'h37;
      3'd5:    b = 8'h61;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gfdf_cfg.sv =====
// ----------------------------------------------------------------------------
// gfdf_cfg
// Configuration registers: minimum delay and replacement delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfdf_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_i,
  input  wire logic [gfdf_pkg::CFG_IDX_W-1:0]   idx_i,
  input  wire logic [gfdf_pkg::CFG_DAT_W-1:0]   data_i,
  output gfdf_pkg::cfg_t                        cfg_o
);

  gfdf_pkg::cfg_t cfg_r, cfg_nxt;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_i) begin
      unique case (idx_i)
        gfdf_pkg::REG_MIN_DELAY:  cfg_nxt.min_delay  = data_i;
        gfdf_pkg::REG_REPL_DELAY: cfg_nxt.repl_delay = data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_delay  <= gfdf_pkg::MIN_DELAY_RST;
      cfg_r.repl_delay <= gfdf_pkg::REPL_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/gfdf_hdr.sv =====
// ----------------------------------------------------------------------------
// gfdf_hdr
// Header recogniser: tracks the first six bytes against both signatures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfdf_hdr (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take_i,
  input  wire logic [7:0] data_i,
  input  wire logic       last_i,
  output gfdf_pkg::hdr_t  hdr_o
);

  logic [gfdf_pkg::HPOS_W-1:0] pos_r, pos_nxt, pos_upd;
  logic                        m87_r, m87_nxt, m87_upd;
  logic                        m89_r, m89_nxt, m89_upd;

  // Compare the current item against both signatures while in the header
  always_comb begin
    pos_upd = pos_r;
    m87_upd = m87_r;
    m89_upd = m89_r;
    if (take_i && (pos_r < gfdf_pkg::HPOS_W'(gfdf_pkg::HDR_LEN))) begin
      if (data_i != gfdf_pkg::sig_byte(pos_r, 1'b0)) m87_upd = 1'b0;
      if (data_i != gfdf_pkg::sig_byte(pos_r, 1'b1)) m89_upd = 1'b0;
      pos_upd = pos_r + 1'b1;
    end
  end

  // Restart on the last item of a stream
  always_comb begin
    pos_nxt = pos_upd;
    m87_nxt = m87_upd;
    m89_nxt = m89_upd;
    if (take_i && last_i) begin
      pos_nxt = '0;
      m87_nxt = 1'b1;
      m89_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      m87_r <= 1'b1;
      m89_r <= 1'b1;
    end else begin
      pos_r <= pos_nxt;
      m87_r <= m87_nxt;
      m89_r <= m89_nxt;
    end
  end

  assign hdr_o.ok = (pos_upd == gfdf_pkg::HPOS_W'(gfdf_pkg::HDR_LEN)) && (m87_upd || m89_upd);

endmodule

`default_nettype wire

// ===== rtl/gfdf_window.sv =====
// ----------------------------------------------------------------------------
// gfdf_window
// Nine-byte window with control block match, delay rewrite and end flush.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gfdf_window (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           take_i,
  input  wire logic [7:0]     data_i,
  input  wire logic           last_i,
  input  wire gfdf_pkg::hdr_t hdr_i,
  input  wire gfdf_pkg::cfg_t cfg_i,
  input  wire logic           out_free_i,
  output logic                in_ready_o,
  output logic                emit_o,
  output logic [7:0]          emit_data_o,
  output logic                emit_last_o
);

  localparam int LAST = gfdf_pkg::WIN_LEN - 1;

  logic [7:0]                 win_r [gfdf_pkg::WIN_LEN];
  logic [7:0]                 win_nxt [gfdf_pkg::WIN_LEN];
  logic [7:0]                 full [gfdf_pkg::WIN_LEN];
  logic [gfdf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       stop_r, stop_nxt;
  gfdf_pkg::win_state_t       state_r, state_nxt;

  logic        is_full;
  logic        mark;
  logic        chk;
  logic [15:0] delay;
  logic        too_big;

  // Place the new item at the fill position, test for a control block and rewrite a short delay
  always_comb begin
    for (int i = 0; i < gfdf_pkg::WIN_LEN; i++) begin
      full[i] = (cnt_r == gfdf_pkg::CNT_W'(i)) ? data_i : win_r[i];
    end
    is_full = (cnt_r == gfdf_pkg::CNT_W'(LAST));
    mark    = (full[0] == gfdf_pkg::GCE_B0) && (full[1] == gfdf_pkg::GCE_B1) &&
              (full[2] == gfdf_pkg::GCE_B2) && (full[3] == gfdf_pkg::GCE_B3) &&
              (full[LAST] == 8'h00);
    chk     = take_i && is_full && hdr_i.ok && !stop_r && mark;
    delay   = {full[6], full[5]};
    too_big = delay > cfg_i.min_delay;
    if (chk && !too_big) begin
      full[5] = cfg_i.repl_delay[7:0];
      full[6] = cfg_i.repl_delay[15:8];
    end
  end

  // Next state, window update and emission
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    stop_nxt    = stop_r;
    win_nxt     = win_r;
    in_ready_o  = 1'b0;
    emit_o      = 1'b0;
    emit_data_o = win_r[0];
    emit_last_o = 1'b0;
    unique case (state_r)
      gfdf_pkg::ST_STREAM: begin
        in_ready_o = out_free_i;
        if (chk && too_big) stop_nxt = 1'b1;
        if (take_i) begin
          if (last_i) begin
            // hold the whole window for the flush
            win_nxt   = full;
            cnt_nxt   = cnt_r + 1'b1;
            stop_nxt  = 1'b0;
            state_nxt = gfdf_pkg::ST_FLUSH;
          end else if (is_full) begin
            // emit the oldest byte and advance
            emit_o      = 1'b1;
            emit_data_o = full[0];
            for (int i = 0; i < LAST; i++) win_nxt[i] = full[i+1];
            win_nxt[LAST] = full[LAST];
          end else begin
            win_nxt = full;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      gfdf_pkg::ST_FLUSH: begin
        // drain one byte a cycle while the output is free, marking the final one
        if (out_free_i) begin
          emit_o      = 1'b1;
          emit_last_o = (cnt_r == gfdf_pkg::CNT_W'(1));
          for (int i = 0; i < LAST; i++) win_nxt[i] = win_r[i+1];
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == gfdf_pkg::CNT_W'(1)) state_nxt = gfdf_pkg::ST_STREAM;
        end
      end
      default: state_nxt = gfdf_pkg::ST_STREAM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfdf_pkg::ST_STREAM;
      cnt_r   <= '0;
      stop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // Window bytes carry no reset
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/gif_frame_delay_fixer_top.sv =====
// ----------------------------------------------------------------------------
// gif_frame_delay_fixer_top
// GIF frame delay fixer: byte stream in, same stream out with short
// graphic control delays rewritten.
// ----------------------------------------------------------------------------
// Takes one byte per cycle in steady state while the output is not stalled,
// and gives each byte out eight items later through a single output
// register; the first eight bytes of a stream produce nothing. When the item
// marked last is taken, the block stops taking input and drains the window
// one byte per cycle while the output is not stalled; up to nine bytes are
// held for the flush, and the drain is paced by the one output register.
// Rewriting is only active after a GIF87a or GIF89a header. Configuration
// writes are always accepted and should be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "gif_frame_delay_fixer_top_macros.svh"

module gif_frame_delay_fixer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_data_in,
  input  wire logic                           in_last_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_data_out,
  output logic                                out_last_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gfdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gfdf_pkg::CFG_DAT_W-1:0] cfg_data
);

  gfdf_pkg::cfg_t cfg;
  gfdf_pkg::hdr_t hdr;

  logic       take;
  logic       out_free;
  logic       emit;
  logic [7:0] emit_data;
  logic       emit_last;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       out_last_r;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  gfdf_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (cfg_valid && cfg_ready),
    .idx_i  (cfg_index),
    .data_i (cfg_data),
    .cfg_o  (cfg)
  );

  gfdf_hdr u_hdr (
    .clk    (clk),
    .rst_n  (rst_n),
    .take_i (take),
    .data_i (in_data_in),
    .last_i (in_last_in),
    .hdr_o  (hdr)
  );

  gfdf_window u_win (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_i      (take),
    .data_i      (in_data_in),
    .last_i      (in_last_in),
    .hdr_i       (hdr),
    .cfg_i       (cfg),
    .out_free_i  (out_free),
    .in_ready_o  (in_ready),
    .emit_o      (emit),
    .emit_data_o (emit_data),
    .emit_last_o (emit_last)
  );

  // Output register: load on emit, drop valid once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_data;
      out_last_r <= emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_last_out = out_last_r;

  // Checks
  `GFDF_ASSERT_NOW(a_no_take_when_blocked, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `GFDF_ASSERT_NEXT(a_flush_after_last, in_valid && in_ready && in_last_in, !in_ready, "input taken during flush")
  `GFDF_ASSERT_NEXT(a_cfg_min_write, cfg_valid && cfg_ready && (cfg_index == gfdf_pkg::REG_MIN_DELAY), cfg.min_delay == $past(cfg_data), "min delay write lost")

endmodule

`default_nettype wire
